FILE: src/bmg_pkg.sv
`timescale 1ns / 1ps
package bmg_pkg;

   // Value fields: unsigned, 8 fraction bits, 0..100 maps to 0..25600.
   localparam int VAL_W = 15;

   // Uniform words and the logarithm path.
   localparam int UNIFORM_BITS = 16;
   localparam int M_W = UNIFORM_BITS + 1;
   localparam int E_W = $clog2(M_W);
   localparam int X_W = 31;
   localparam int SQ_STEPS = 16;
   localparam int L_W = $clog2(UNIFORM_BITS + 1) + SQ_STEPS;
   localparam int LP_W = L_W + 31;
   // -2 ln u1 in Q32 stays below 2^37 for the largest logarithm.
   localparam int R_W = 37;
   localparam int ROOT_W = (R_W + 1) / 2;

   // Sine path.
   localparam int PH_W = 32;
   localparam int X2_W = 32;
   localparam int HORNER_STEPS = 5;

   localparam logic [30:0] Q30_ONE = 31'h4000_0000;
   localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

   // Pipeline depths.
   localparam int LOG_LAT = 1 + SQ_STEPS + 2;
   localparam int SQRT_LAT = ROOT_W;
   localparam int SIN_LAT = 3 + 3 * HORNER_STEPS + 1;
   localparam int ALIGN_LAT = LOG_LAT + SQRT_LAT;
   localparam int SIN_PAD = ALIGN_LAT - SIN_LAT;

   localparam logic [1:0] HIT_NONE = 2'd0;
   localparam logic [1:0] HIT_LOW  = 2'd1;
   localparam logic [1:0] HIT_HIGH = 2'd2;

   typedef struct packed {
      logic           neg;
      logic [X_W-1:0] s;
   } sin_out_type;

   typedef struct packed {
      logic [VAL_W-1:0] mean;
      logic [VAL_W-1:0] spread;
   } scale_type;

   // Horner divisors of the Taylor series, innermost first.
   function automatic logic [6:0] horner_div(input int i);
      logic [6:0] d;
      case (i)
         0: d = 7'd110;
         1: d = 7'd72;
         2: d = 7'd42;
         3: d = 7'd20;
         default: d = 7'd6;
      endcase
      return d;
   endfunction

   // floor(2^32 / divisor), used for division by reciprocal.
   function automatic logic [31:0] horner_recip(input int i);
      logic [31:0] r;
      case (i)
         0: r = 32'd39045157;
         1: r = 32'd59652323;
         2: r = 32'd102261126;
         3: r = 32'd214748364;
         default: r = 32'd715827882;
      endcase
      return r;
   endfunction

endpackage

FILE: src/bmg_req_if.sv
`timescale 1ns / 1ps
interface bmg_req_if;
   import bmg_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [VAL_W-1:0]        mean_value;
   logic [VAL_W-1:0]        spread;
   logic [UNIFORM_BITS-1:0] uniform_a;
   logic [UNIFORM_BITS-1:0] uniform_b;

   modport source (output valid, mean_value, spread, uniform_a, uniform_b, input ready);
   modport sink (input valid, mean_value, spread, uniform_a, uniform_b, output ready);
endinterface

FILE: src/bmg_rsp_if.sv
`timescale 1ns / 1ps
interface bmg_rsp_if;
   import bmg_pkg::*;
   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] sample;
   logic [1:0]       clamp_hit;

   modport source (output valid, sample, clamp_hit, input ready);
   modport sink (input valid, sample, clamp_hit, output ready);
endinterface

FILE: src/bmg_log.sv
`timescale 1ns / 1ps
module bmg_log (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             valid_in,
   input  logic [bmg_pkg::UNIFORM_BITS-1:0] uniform_a,
   output logic                             valid_out,
   output logic [bmg_pkg::R_W-1:0]          rad_sq
);
   import bmg_pkg::*;

   logic [M_W-1:0]       m;
   logic [E_W-1:0]       e_in;
   logic [M_W+29:0]      norm_wide;

   logic [X_W-1:0]       x_ff [0:SQ_STEPS];
   logic [SQ_STEPS-1:0]  f_ff [0:SQ_STEPS];
   logic [E_W-1:0]       e_ff [0:SQ_STEPS];
   logic                 v_ff [0:SQ_STEPS];

   logic [L_W-1:0]       top_val;
   logic [L_W-1:0]       sub_val;
   logic [L_W-1:0]       l_in;
   logic [L_W-1:0]       l_ff;
   logic                 lv_ff;
   logic [LP_W-1:0]      lp;
   logic [R_W-1:0]       r_ff;
   logic                 rv_ff;

   // Normalize m to Q1.30 around its leading one.
   always_comb begin
      m = {1'b0, uniform_a} + M_W'(1);
      e_in = '0;
      for (int i = 0; i < M_W; i++) begin
         if (m[i]) begin
            e_in = E_W'(i);
         end
      end
      norm_wide = {m, 30'b0} >> e_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= norm_wide[X_W-1:0];
         f_ff[0] <= '0;
         e_ff[0] <= e_in;
      end
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= valid_in;
      end
   end

   // One fraction bit of log2 per stage by squaring.
   for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_sq
      logic [2*X_W-1:0] sq;
      logic [31:0]      y;
      assign sq = x_ff[k-1] * x_ff[k-1];
      assign y = sq[61:30];
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k] <= y[31] ? y[31:1] : y[30:0];
            f_ff[k] <= {f_ff[k-1][SQ_STEPS-2:0], y[31]};
            e_ff[k] <= e_ff[k-1];
         end
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   assign top_val = L_W'(UNIFORM_BITS) << SQ_STEPS;
   assign sub_val = {e_ff[SQ_STEPS], f_ff[SQ_STEPS]};
   assign l_in = (top_val >= sub_val) ? (top_val - sub_val) : '0;
   assign lp = l_ff * LP_W'(TWO_LN2_Q30);

   always_ff @(posedge clock) begin
      if (en) begin
         l_ff <= l_in;
         r_ff <= lp[R_W+13:14];
      end
      if (reset) begin
         lv_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else if (en) begin
         lv_ff <= v_ff[SQ_STEPS];
         rv_ff <= lv_ff;
      end
   end

   assign valid_out = rv_ff;
   assign rad_sq = r_ff;
endmodule

FILE: src/bmg_sqrt.sv
`timescale 1ns / 1ps
module bmg_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       valid_in,
   input  logic [bmg_pkg::R_W-1:0]    rad_sq,
   output logic                       valid_out,
   output logic [bmg_pkg::ROOT_W-1:0] root
);
   import bmg_pkg::*;

   logic [R_W-1:0]    rem_s  [0:ROOT_W];
   logic [ROOT_W-1:0] root_s [0:ROOT_W];
   logic              v_s    [0:ROOT_W];
   logic [R_W-1:0]    rem_ff  [0:ROOT_W-1];
   logic [ROOT_W-1:0] root_ff [0:ROOT_W-1];
   logic              v_ff    [0:ROOT_W-1];

   assign rem_s[0] = rad_sq;
   assign root_s[0] = '0;
   assign v_s[0] = valid_in;

   // One root bit per stage, most significant first.
   for (genvar j = 0; j < ROOT_W; j++) begin : g_bit
      localparam int K = ROOT_W - 1 - j;
      logic [R_W:0] inc;
      logic         take;
      assign inc = ((R_W+1)'(root_s[j]) << (K + 1)) | ((R_W+1)'(1) << (2 * K));
      assign take = {1'b0, rem_s[j]} >= inc;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= take ? R_W'({1'b0, rem_s[j]} - inc) : rem_s[j];
            root_ff[j] <= take ? (root_s[j] | (ROOT_W'(1) << K)) : root_s[j];
         end
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (en) begin
            v_ff[j] <= v_s[j];
         end
      end
      assign rem_s[j+1] = rem_ff[j];
      assign root_s[j+1] = root_ff[j];
      assign v_s[j+1] = v_ff[j];
   end

   assign valid_out = v_s[ROOT_W];
   assign root = root_s[ROOT_W];
endmodule

FILE: src/bmg_sin.sv
`timescale 1ns / 1ps
module bmg_sin (
   input  logic                             clock,
   input  logic                             en,
   input  logic [bmg_pkg::UNIFORM_BITS-1:0] uniform_b,
   output bmg_pkg::sin_out_type             sin_out
);
   import bmg_pkg::*;

   localparam int CARRY_D = 3 * HORNER_STEPS + 1;

   logic [UNIFORM_BITS-1:0] ub1;
   logic [PH_W-1:0]         phase;
   logic [X_W-1:0]          t_in;
   logic [X_W-1:0]          t_ff;
   logic                    tneg_ff;
   logic [2*X_W-1:0]        prod_x;
   logic [X_W-1:0]          x_ff;
   logic                    xneg_ff;
   logic [2*X_W-1:0]        prod_x2;

   logic [X_W-1:0]  cx_ff   [0:CARRY_D-1];
   logic [X2_W-1:0] cx2_ff  [0:CARRY_D-1];
   logic            cneg_ff [0:CARRY_D-1];

   logic [X2_W-1:0] n_ff  [0:HORNER_STEPS-1];
   logic [X2_W-1:0] nb_ff [0:HORNER_STEPS-1];
   logic [31:0]     qe_ff [0:HORNER_STEPS-1];
   logic [X_W-1:0]  g_ff  [0:HORNER_STEPS-1];

   logic [2*X_W-1:0] prod_s;
   sin_out_type      out_ff;

   // Phase in turns; fold into the first quadrant.
   assign ub1 = uniform_b + UNIFORM_BITS'(1);
   assign phase = {ub1, (PH_W-UNIFORM_BITS)'(0)};
   assign t_in = phase[30] ? (Q30_ONE - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
   assign prod_x = t_ff * (2*X_W)'(HALF_PI_Q30);
   assign prod_x2 = x_ff * x_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff <= t_in;
         tneg_ff <= phase[31];
         x_ff <= prod_x[60:30];
         xneg_ff <= tneg_ff;
         cx_ff[0] <= x_ff;
         cx2_ff[0] <= prod_x2[61:30];
         cneg_ff[0] <= xneg_ff;
         for (int j = 1; j < CARRY_D; j++) begin
            cx_ff[j] <= cx_ff[j-1];
            cx2_ff[j] <= cx2_ff[j-1];
            cneg_ff[j] <= cneg_ff[j-1];
         end
      end
   end

   // Each Horner step: multiply, divide by reciprocal, correct and subtract.
   for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_horner
      localparam int JA = 3 * i + 1;
      localparam logic [6:0] DIV = horner_div(i);
      localparam logic [31:0] RECIP = horner_recip(i);
      logic [X_W-1:0]    g_prev;
      logic [X2_W+X_W-1:0] prod_a;
      logic [63:0]       prod_b;
      logic [31:0]       rem;
      logic [31:0]       qd;
      if (i == 0) begin : g_first
         assign g_prev = Q30_ONE;
      end else begin : g_next
         assign g_prev = g_ff[i-1];
      end
      assign prod_a = cx2_ff[JA-1] * g_prev;
      assign prod_b = n_ff[i] * 64'(RECIP);
      assign rem = nb_ff[i] - 32'(qe_ff[i] * 32'(DIV));
      assign qd = (rem >= 32'(DIV)) ? (qe_ff[i] + 32'd1) : qe_ff[i];
      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[i] <= prod_a[61:30];
            qe_ff[i] <= prod_b[63:32];
            nb_ff[i] <= n_ff[i];
            g_ff[i] <= Q30_ONE - qd[30:0];
         end
      end
   end

   assign prod_s = cx_ff[CARRY_D-1] * g_ff[HORNER_STEPS-1];

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff.s <= prod_s[60:30];
         out_ff.neg <= cneg_ff[CARRY_D-1];
      end
   end

   assign sin_out = out_ff;
endmodule

FILE: src/box_muller_gaussian_sample.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle; the whole pipeline advances together and
// holds when the output register is full and rsp.ready is low.
// Reset (synchronous, active high) empties the pipeline and sets the clamp
// window to 0 .. 25600.
module box_muller_gaussian_sample (
   input  logic                         clock,
   input  logic                         reset,
   bmg_req_if.sink                      req,
   bmg_rsp_if.source                    rsp,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [2:0]                   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import bmg_pkg::*;

   // Register index taken from the word address.
   localparam logic REG_LOW  = 1'b0;
   localparam logic REG_HIGH = 1'b1;

   logic [VAL_W-1:0] low_ff;
   logic [VAL_W-1:0] high_ff;
   logic             en;

   logic              log_valid;
   logic [R_W-1:0]    rad_sq;
   logic              sq_valid;
   logic [ROOT_W-1:0] root;
   sin_out_type       sin_out;

   scale_type   md_ff [0:ALIGN_LAT-1];
   sin_out_type sd_ff [0:SIN_PAD-1];

   logic [ROOT_W+X_W-1:0]   prod_d;
   logic [ROOT_W-1:0]       d_ff;
   logic                    dv_ff;
   scale_type               dm_ff;
   logic                    dneg_ff;

   logic [VAL_W+ROOT_W:0]   prod_t;
   logic [ROOT_W-1:0]       term_ff;
   logic                    ev_ff;
   logic [VAL_W-1:0]        emean_ff;
   logic                    eneg_ff;

   logic signed [ROOT_W+1:0] sum;
   logic signed [ROOT_W+1:0] low_s;
   logic signed [ROOT_W+1:0] high_s;
   logic [VAL_W-1:0]         sample_in;
   logic [1:0]               hit_in;
   logic [VAL_W-1:0]         sample_ff;
   logic [1:0]               hit_ff;
   logic                     out_valid_ff;

   // Configuration port. Writes land in the access phase; reads are
   // combinational and pready never stalls.
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff <= '0;
         high_ff <= VAL_W'(25600);
      end else if (psel && penable && pwrite) begin
         case (paddr[2])
            REG_LOW:  low_ff <= pwdata[VAL_W-1:0];
            REG_HIGH: high_ff <= pwdata[VAL_W-1:0];
            default:  ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_LOW:  prdata = 32'(low_ff);
         REG_HIGH: prdata = 32'(high_ff);
         default:  prdata = '0;
      endcase
   end

   // Every stage moves when the output register is free or being read.
   // The result word sits in its own register, so a new request word is
   // still taken in the same cycle in which a finished one is handed off.
   assign en = !out_valid_ff || rsp.ready;
   assign req.ready = en;

   // Radius path: -2 ln u1, then its square root.
   bmg_log u_log (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (req.valid),
      .uniform_a (req.uniform_a),
      .valid_out (log_valid),
      .rad_sq    (rad_sq)
   );

   bmg_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (log_valid),
      .rad_sq    (rad_sq),
      .valid_out (sq_valid),
      .root      (root)
   );

   // Angle path: sin(2 pi u2) as a magnitude and a sign.
   bmg_sin u_sin (
      .clock     (clock),
      .en        (en),
      .uniform_b (req.uniform_b),
      .sin_out   (sin_out)
   );

   // Mean and spread ride along until the radius is ready. The sine path
   // is shorter and is padded so both meet at the same stage.
   always_ff @(posedge clock) begin
      if (en) begin
         md_ff[0] <= '{mean: req.mean_value, spread: req.spread};
         for (int j = 1; j < ALIGN_LAT; j++) begin
            md_ff[j] <= md_ff[j-1];
         end
         sd_ff[0] <= sin_out;
         for (int j = 1; j < SIN_PAD; j++) begin
            sd_ff[j] <= sd_ff[j-1];
         end
      end
   end

   // Deviate magnitude, then the scaled and rounded term.
   assign prod_d = root * sd_ff[SIN_PAD-1].s;
   assign prod_t = (dm_ff.spread * d_ff) + (VAL_W+ROOT_W+1)'(1 << 15);

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= prod_d[ROOT_W+29:30];
         dm_ff <= md_ff[ALIGN_LAT-1];
         dneg_ff <= sd_ff[SIN_PAD-1].neg;
         term_ff <= prod_t[VAL_W+ROOT_W:16];
         emean_ff <= dm_ff.mean;
         eneg_ff <= dneg_ff;
      end
      if (reset) begin
         dv_ff <= 1'b0;
         ev_ff <= 1'b0;
      end else if (en) begin
         dv_ff <= sq_valid;
         ev_ff <= dv_ff;
      end
   end

   // Signed sum and clamp. The low bound is tested first, so crossed
   // bounds send every sum at or above the low bound to the high bound.
   always_comb begin
      low_s = $signed((ROOT_W+2)'(low_ff));
      high_s = $signed((ROOT_W+2)'(high_ff));
      if (eneg_ff) begin
         sum = $signed((ROOT_W+2)'(emean_ff)) - $signed((ROOT_W+2)'(term_ff));
      end else begin
         sum = $signed((ROOT_W+2)'(emean_ff)) + $signed((ROOT_W+2)'(term_ff));
      end
      if (sum < low_s) begin
         sample_in = low_ff;
         hit_in = HIT_LOW;
      end else if (sum > high_s) begin
         sample_in = high_ff;
         hit_in = HIT_HIGH;
      end else begin
         sample_in = sum[VAL_W-1:0];
         hit_in = HIT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sample_ff <= sample_in;
         hit_ff <= hit_in;
      end
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= ev_ff;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.sample = sample_ff;
   assign rsp.clamp_hit = hit_ff;
endmodule

FILE: tb/sv/box_muller_gaussian_sample_tb.sv
`timescale 1ns / 1ps
// Checks the gaussian sample block against its own integer arithmetic: every
// word sent on req is predicted here and compared with what comes back on rsp.
module box_muller_gaussian_sample_tb;
   import bmg_pkg::*;

   localparam logic [2:0] ADDR_LOW  = 3'd0;
   localparam logic [2:0] ADDR_HIGH = 3'd4;
   localparam int PIPE_LAT  = 41;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [VAL_W-1:0]        mean_value;
      logic [VAL_W-1:0]        spread;
      logic [UNIFORM_BITS-1:0] uniform_a;
      logic [UNIFORM_BITS-1:0] uniform_b;
   } draw_type;

   typedef struct packed {
      logic [VAL_W-1:0] sample;
      logic [1:0]       clamp_hit;
   } sample_type;

   logic clock;
   logic reset;
   logic psel, penable, pwrite, pready;
   logic [2:0] paddr;
   logic [31:0] pwdata, prdata;

   bmg_req_if req ();
   bmg_rsp_if rsp ();

   box_muller_gaussian_sample dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Clamp window as the block should hold it.
   logic [VAL_W-1:0] window_low, window_high;

   draw_type   draw_queue[$];
   sample_type expected_samples[$];
   int         errors = 0;
   longint     cycle_count = 0;

   // Idling controls. quiet_tail turns off all random idling near the end;
   // hold_rsp_cycles asks the monitor for one long stall.
   bit quiet_tail = 0;
   int hold_rsp_cycles = 0;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL box_muller_gaussian_sample");
         $finish;
      end
   end

   // -2 ln(m / 2^16) in Q32 via the repeated-squaring logarithm.
   function automatic logic [63:0] neg_two_ln(input logic [63:0] m);
      logic [63:0] e, x, frac, l;
      e = 0;
      frac = 0;
      while (e < 40 && (m >> (e + 1)) != 0) e++;
      x = (e <= 30) ? (m << (30 - e)) : (m >> (e - 30));
      for (int i = 0; i < 16; i++) begin
         x = (x * x) >> 30;
         frac = frac << 1;
         if (x >= (64'd1 << 31)) begin
            frac = frac | 1;
            x = x >> 1;
         end
      end
      l = 64'(UNIFORM_BITS) << 16;
      if (l >= (e << 16) + frac) l = l - ((e << 16) + frac);
      else l = 0;
      return (l * 64'd1488522236) >> 14;
   endfunction

   function automatic logic [63:0] int_root(input logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // sin(pi/2 * t) in Q30, Horner on the Taylor series through x^11.
   function automatic logic [63:0] quarter_sine(input logic [63:0] t);
      logic [63:0] x, x2, g;
      int divisors[5];
      divisors = '{110, 72, 42, 20, 6};
      x = (t * 64'd1686629713) >> 30;
      x2 = (x * x) >> 30;
      g = 64'd1 << 30;
      for (int i = 0; i < 5; i++)
         g = (64'd1 << 30) - ((x2 * g) >> 30) / divisors[i];
      return (x * g) >> 30;
   endfunction

   function automatic sample_type predict_sample(input draw_type d);
      logic [63:0] radius, phase, quadrant, f, t, s, dev, term;
      longint sum;
      sample_type res;
      radius = int_root(neg_two_ln(64'(d.uniform_a) + 1));
      phase = ((64'(d.uniform_b) + 1) << (32 - UNIFORM_BITS)) & 64'hFFFF_FFFF;
      quadrant = phase >> 30;
      f = phase & ((64'd1 << 30) - 1);
      t = quadrant[0] ? ((64'd1 << 30) - f) : f;
      s = quarter_sine(t);
      dev = (radius * s) >> 30;
      term = (64'(d.spread) * dev + (64'd1 << 15)) >> 16;
      sum = (quadrant >= 2) ? longint'(d.mean_value) - longint'(term)
                            : longint'(d.mean_value) + longint'(term);
      if (sum < longint'(window_low)) begin
         res.sample = window_low;
         res.clamp_hit = HIT_LOW;
      end else if (sum > longint'(window_high)) begin
         res.sample = window_high;
         res.clamp_hit = HIT_HIGH;
      end else begin
         res.sample = sum[VAL_W-1:0];
         res.clamp_hit = HIT_NONE;
      end
      return res;
   endfunction

   // Set at the edge that takes a request word, so the driver knows at the
   // following falling edge whether the word it holds has gone.
   bit req_taken = 0;

   // Driver: offers the head of the pending queue, with random gaps between
   // words. Valid stays up across back-to-back words without a dip.
   int send_gap = 0;
   bit sender_paused = 0;
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 0;
      end else begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req.valid <= 0;
         end else if (sender_paused || draw_queue.size() == 0) begin
            req.valid <= 0;
         end else if (!(req.valid && !req_taken) && !quiet_tail &&
                      $urandom_range(0, 19) == 0) begin
            send_gap <= $urandom_range(1, 16);
            req.valid <= 0;
         end else begin
            req.valid      <= 1;
            req.mean_value <= draw_queue[0].mean_value;
            req.spread     <= draw_queue[0].spread;
            req.uniform_a  <= draw_queue[0].uniform_a;
            req.uniform_b  <= draw_queue[0].uniform_b;
         end
      end
   end

   // Predict on acceptance, so the window in force is the one just written.
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) begin
         expected_samples.push_back(predict_sample({req.mean_value, req.spread,
                                                    req.uniform_a, req.uniform_b}));
         void'(draw_queue.pop_front());
      end
      req_taken <= !reset && req.valid && req.ready;
   end

   // Monitor: random ready bursts, one long requested stall, and the check of
   // every accepted result word against the oldest prediction.
   int stall_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 0;
      end else if (hold_rsp_cycles > 0) begin
         stall_left <= hold_rsp_cycles;
         hold_rsp_cycles <= 0;
         rsp.ready <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp.ready <= 0;
      end else if (!quiet_tail && $urandom_range(0, 14) == 0) begin
         stall_left <= $urandom_range(1, 16);
         rsp.ready <= 0;
      end else begin
         rsp.ready <= 1;
      end
   end

   always @(posedge clock) begin
      sample_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_samples.size() == 0) begin
            $display("%0t: unexpected word sample=%0d clamp_hit=%0d", $time,
                     rsp.sample, rsp.clamp_hit);
            errors++;
         end else begin
            want = expected_samples.pop_front();
            if (rsp.sample !== want.sample) begin
               $display("%0t: sample expected %0d actual %0d", $time,
                        want.sample, rsp.sample);
               errors++;
            end
            if (rsp.clamp_hit !== want.clamp_hit) begin
               $display("%0t: clamp_hit expected %0d actual %0d", $time,
                        want.clamp_hit, rsp.clamp_hit);
               errors++;
            end
         end
      end
   end

   // One APB write: setup cycle, then access cycle.
   task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
      @(negedge clock);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= addr;
      pwdata <= value;
      @(negedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (addr == ADDR_LOW) window_low = value[VAL_W-1:0];
      else window_high = value[VAL_W-1:0];
      @(negedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
   endtask

   task automatic wait_drained();
      while (draw_queue.size() != 0 || req.valid || expected_samples.size() != 0)
         @(posedge clock);
      repeat (PIPE_LAT + 4) @(posedge clock);
   endtask

   task automatic set_window(input logic [VAL_W-1:0] lo, input logic [VAL_W-1:0] hi);
      wait_drained();
      write_register(ADDR_LOW, {17'd0, lo});
      write_register(ADDR_HIGH, {17'd0, hi});
   endtask

   // Mostly in-range values with occasional full-width ones, so every bit of
   // every field toggles.
   function automatic logic [VAL_W-1:0] random_value();
      return ($urandom_range(0, 9) == 0) ? VAL_W'($urandom) : VAL_W'($urandom_range(0, 25600));
   endfunction

   task automatic queue_random(input int count);
      draw_type d;
      for (int i = 0; i < count; i++) begin
         d.mean_value = random_value();
         d.spread     = random_value();
         d.uniform_a  = UNIFORM_BITS'($urandom);
         d.uniform_b  = UNIFORM_BITS'($urandom);
         draw_queue.push_back(d);
      end
   endtask

   initial begin
      reset = 1;
      psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
      req.valid = 0; req.mean_value = 0; req.spread = 0;
      req.uniform_a = 0; req.uniform_b = 0;
      rsp.ready = 0;
      window_low = 0;
      window_high = 25600;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed words under the reset window: field extremes, u1 of one
      // (radius zero), the full phase turn, each quadrant edge, both clamps.
      draw_queue.push_back('{12800, 2560, 16'hFFFF, 16'h1234});
      draw_queue.push_back('{12800, 25600, 16'h0000, 16'hFFFF});
      draw_queue.push_back('{0, 25600, 16'h0000, 16'hBFFF});
      draw_queue.push_back('{25600, 25600, 16'h0000, 16'h3FFF});
      draw_queue.push_back('{25600, 0, 16'h0000, 16'h3FFF});
      draw_queue.push_back('{0, 0, 16'h0000, 16'h0000});
      draw_queue.push_back('{15'h7FFF, 15'h7FFF, 16'h0000, 16'h7FFF});
      draw_queue.push_back('{15'h7FFF, 15'h7FFF, 16'h0000, 16'hBFFF});
      draw_queue.push_back('{12800, 5000, 16'h8000, 16'h1FFF});
      draw_queue.push_back('{12800, 5000, 16'h0001, 16'h5FFF});
      draw_queue.push_back('{12800, 5000, 16'h7FFF, 16'h9FFF});
      draw_queue.push_back('{12800, 5000, 16'hFFFE, 16'hDFFF});
      draw_queue.push_back('{100, 25600, 16'h0000, 16'hFFFE});
      wait_drained();

      // Narrow window, then crossed bounds, then the full-width extremes.
      set_window(10000, 15000);
      draw_queue.push_back('{12800, 25600, 16'h0000, 16'h3FFF});
      draw_queue.push_back('{12800, 25600, 16'h0000, 16'hBFFF});
      draw_queue.push_back('{12800, 100, 16'h4000, 16'h0100});
      queue_random(60);
      set_window(20000, 5000);
      draw_queue.push_back('{12800, 0, 16'hFFFF, 16'h0000});
      draw_queue.push_back('{0, 0, 16'hFFFF, 16'h0000});
      queue_random(60);
      set_window(15'h7FFF, 15'h7FFF);
      queue_random(40);
      set_window(0, 0);
      queue_random(40);

      // Long receiver stall while the sender keeps offering words, so the
      // pipeline fills and req.ready drops.
      set_window(0, 15'h7FFF);
      queue_random(150);
      hold_rsp_cycles = 200;

      // Sender pause until every outstanding word has returned.
      while (draw_queue.size() != 0) @(posedge clock);
      sender_paused = 1;
      while (req.valid || expected_samples.size() != 0) @(posedge clock);
      sender_paused = 0;

      set_window(2560, 23040);
      queue_random(380);
      while (draw_queue.size() > 120) @(posedge clock);
      // Final stretch runs at full rate on both sides.
      quiet_tail = 1;

      wait_drained();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("PASS box_muller_gaussian_sample");
      end else begin
         $display("FAIL box_muller_gaussian_sample");
      end
      $finish;
   end
endmodule
